/* hdl/wbcc_pkg.sv */
// Shared types and constants for the work/break countdown controller.
package wbcc_pkg;

	localparam int unsigned NowW   = 32;
	localparam int unsigned IntvW  = 20;
	localparam int unsigned ModeW  = 4;
	localparam int unsigned CountW = 6;
	localparam int unsigned ToneW  = 2;

	localparam logic [ModeW-1:0] MODE_IDLE      = 4'd0;
	localparam logic [ModeW-1:0] MODE_TMR_SEL   = 4'd1;
	localparam logic [ModeW-1:0] MODE_CYC_SEL   = 4'd2;
	localparam logic [ModeW-1:0] MODE_TMR_SETUP = 4'd4;
	localparam logic [ModeW-1:0] MODE_WRK_SETUP = 4'd5;
	localparam logic [ModeW-1:0] MODE_TMR_RUN   = 4'd6;
	localparam logic [ModeW-1:0] MODE_TMR_DONE  = 4'd7;
	localparam logic [ModeW-1:0] MODE_BRK_SETUP = 4'd8;
	localparam logic [ModeW-1:0] MODE_WRK_RUN   = 4'd9;
	localparam logic [ModeW-1:0] MODE_BRK_RUN   = 4'd10;
	localparam logic [ModeW-1:0] MODE_SET_OVER  = 4'd11;

	localparam logic [ToneW-1:0] TONE_NONE  = 2'd0;
	localparam logic [ToneW-1:0] TONE_SHORT = 2'd1;
	localparam logic [ToneW-1:0] TONE_LONG  = 2'd2;

	localparam logic [CountW-1:0] SEC_IDLE = 6'd60;
	localparam logic [CountW-1:0] SEC_MAX  = 6'd59;
	localparam logic [CountW-1:0] MIN_MAX  = 6'd59;
	localparam logic [CountW-1:0] MIN_ONE  = 6'd1;

	localparam logic [IntvW-1:0] INTERVAL_RST = 20'd1000;

	// APB register index
	localparam logic REG_INTERVAL = 1'b0;

	typedef struct packed {
		logic [ModeW-1:0]  mode;
		logic [CountW-1:0] work_min;
		logic [CountW-1:0] brk_min;
		logic [CountW-1:0] sec;
		logic [CountW-1:0] saved_work;
		logic [CountW-1:0] saved_brk;
		logic [NowW-1:0]   last_ms;
	} state_t;

	typedef struct packed {
		logic [ModeW-1:0]  mode;
		logic [CountW-1:0] work_count;
		logic [CountW-1:0] break_count;
		logic [CountW-1:0] seconds_left;
		logic [ToneW-1:0]  tone;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
	} buf_ctl_t;

endpackage

/* hdl/work_break_countdown_controller_unit.sv */
// Flow: an accepted poll transaction is registered into stage 1, evaluated there, and written into the
//   result buffer when stage 1 retires; its result transaction is then taken from the buffer.
// Throughput: one poll per cycle; poll_ready falls only when the input register is
//   held behind a full two-entry result buffer.
// Reset (arst_n low, asynchronous): mode 0, minutes 1/1, seconds 60, saved minutes 0,
//   last step time 0, interval 1000 ms, pipeline and result buffer empty.
module work_break_countdown_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// poll channel
	input  logic        poll_valid,
	output logic        poll_ready,
	input  logic [31:0] now_ms,
	input  logic        start_pressed,
	input  logic        adjust_pressed,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [3:0]  mode,
	output logic [5:0]  work_count,
	output logic [5:0]  break_count,
	output logic [5:0]  seconds_left,
	output logic [1:0]  tone
);

	logic [wbcc_pkg::IntvW-1:0] interval_ms;

	// Stage 1: registered poll transaction
	logic                      v_s1;
	logic [wbcc_pkg::NowW-1:0] now_s1;
	logic                      start_s1;
	logic                      adjust_s1;

	// Architectural controller state, updated when stage 1 retires
	wbcc_pkg::state_t st_q;
	wbcc_pkg::state_t st_nxt;
	wbcc_pkg::res_t   res_s1;
	wbcc_pkg::res_t   res_out;

	wbcc_pkg::buf_ctl_t buf_ctl;
	logic               buf_space;
	logic               buf_valid;
	logic               adv;
	logic               poll_acc;

	wbcc_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.interval_ms(interval_ms)
	);

	// Stage 1 retires whenever the result buffer has a free slot
	assign adv        = v_s1 && buf_space;
	assign poll_ready = !v_s1 || buf_space;
	assign poll_acc   = poll_valid && poll_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (poll_ready) begin
			v_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_acc) begin
			now_s1    <= now_ms;
			start_s1  <= start_pressed;
			adjust_s1 <= adjust_pressed;
		end
	end

	// Button rules and countdown step in a single combinational pass
	wbcc_step u_step (
		.st            (st_q),
		.interval_ms   (interval_ms),
		.now_ms        (now_s1),
		.start_pressed (start_s1),
		.adjust_pressed(adjust_s1),
		.nxt           (st_nxt),
		.res           (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode       <= wbcc_pkg::MODE_IDLE;
			st_q.work_min   <= wbcc_pkg::MIN_ONE;
			st_q.brk_min    <= wbcc_pkg::MIN_ONE;
			st_q.sec        <= wbcc_pkg::SEC_IDLE;
			st_q.saved_work <= '0;
			st_q.saved_brk  <= '0;
			st_q.last_ms    <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	assign buf_ctl.push = adv;
	assign buf_ctl.pop  = buf_valid && result_ready;

	wbcc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (buf_ctl),
		.din      (res_s1),
		.dout     (res_out),
		.not_empty(buf_valid),
		.has_space(buf_space)
	);

	assign result_valid = buf_valid;
	assign mode         = res_out.mode;
	assign work_count   = res_out.work_count;
	assign break_count  = res_out.break_count;
	assign seconds_left = res_out.seconds_left;
	assign tone         = res_out.tone;

	// The long tone is only raised on the poll that moves work into break
	a_long_tone_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && tone == wbcc_pkg::TONE_LONG) |-> mode == wbcc_pkg::MODE_BRK_RUN)
		else $error("long tone outside break start");

	// Short tones only accompany the done and set-over modes
	a_short_tone_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && tone == wbcc_pkg::TONE_SHORT) |->
		(mode == wbcc_pkg::MODE_TMR_DONE || mode == wbcc_pkg::MODE_SET_OVER))
		else $error("short tone in unexpected mode");

	// A stalled stage 1 keeps its transaction and leaves the controller state alone
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !buf_space) |=> (v_s1 && $stable(now_s1) && $stable(st_q)))
		else $error("stage 1 lost or changed under stall");

	// Seconds count never leaves 0..60
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.sec <= wbcc_pkg::SEC_IDLE)
		else $error("seconds count out of range");

endmodule

/* hdl/wbcc_step.sv */
// Next-state and result logic for one poll transaction.
module wbcc_step (
	input  wbcc_pkg::state_t                st,
	input  logic [wbcc_pkg::IntvW-1:0]      interval_ms,
	input  logic [wbcc_pkg::NowW-1:0]       now_ms,
	input  logic                            start_pressed,
	input  logic                            adjust_pressed,
	output wbcc_pkg::state_t                nxt,
	output wbcc_pkg::res_t                  res
);

	logic [wbcc_pkg::NowW-1:0]   elapsed;
	logic                        step_due;
	logic [wbcc_pkg::CountW-1:0] cd_min;
	logic [wbcc_pkg::CountW-1:0] cd_min_nxt;
	logic [wbcc_pkg::CountW-1:0] cd_sec_nxt;
	logic                        cd_done;
	logic [wbcc_pkg::CountW-1:0] work_bump;
	logic [wbcc_pkg::CountW-1:0] work_drop;
	logic [wbcc_pkg::CountW-1:0] brk_bump;
	logic [wbcc_pkg::CountW-1:0] brk_drop;
	logic [wbcc_pkg::ToneW-1:0]  tone;
	logic [wbcc_pkg::ModeW-1:0]  m;
	logic                        s;
	logic                        a;

	assign m = st.mode;
	assign s = start_pressed;
	assign a = adjust_pressed;

	assign work_bump = (st.work_min > wbcc_pkg::MIN_MAX) ? wbcc_pkg::MIN_ONE
	                                                      : st.work_min + 6'd1;
	assign work_drop = (st.work_min != '0) ? st.work_min - 6'd1 : st.work_min;
	assign brk_bump  = (st.brk_min > wbcc_pkg::MIN_MAX) ? wbcc_pkg::MIN_ONE
	                                                     : st.brk_min + 6'd1;
	assign brk_drop  = (st.brk_min != '0) ? st.brk_min - 6'd1 : st.brk_min;

	// Countdown: wrapping elapsed time against the interval, then borrow
	assign elapsed  = now_ms - st.last_ms;
	assign step_due = elapsed >= {{(wbcc_pkg::NowW-wbcc_pkg::IntvW){1'b0}}, interval_ms};
	assign cd_min   = (m == wbcc_pkg::MODE_BRK_RUN) ? st.brk_min : st.work_min;

	always_comb begin
		cd_done    = 1'b0;
		cd_min_nxt = cd_min;
		if (st.sec != '0) begin
			cd_sec_nxt = st.sec - 6'd1;
		end else if (cd_min != '0) begin
			cd_sec_nxt = wbcc_pkg::SEC_MAX;
			cd_min_nxt = cd_min - 6'd1;
		end else begin
			cd_sec_nxt = wbcc_pkg::SEC_IDLE;
			cd_done    = 1'b1;
		end
	end

	always_comb begin
		nxt  = st;
		tone = wbcc_pkg::TONE_NONE;
		if (s && (m == wbcc_pkg::MODE_TMR_SEL || m == wbcc_pkg::MODE_CYC_SEL)) begin
			nxt.mode = m + 4'd1;
		end else if (a && m == wbcc_pkg::MODE_TMR_SEL) begin
			nxt.mode = wbcc_pkg::MODE_TMR_SETUP;
		end else if (a && m == wbcc_pkg::MODE_CYC_SEL) begin
			nxt.mode = wbcc_pkg::MODE_WRK_SETUP;
		end else if (a && (m == wbcc_pkg::MODE_TMR_SETUP || m == wbcc_pkg::MODE_WRK_SETUP)) begin
			nxt.work_min = work_bump;
		end else if (s && m == wbcc_pkg::MODE_WRK_SETUP) begin
			nxt.work_min   = work_drop;
			nxt.saved_work = work_drop;
			nxt.mode       = wbcc_pkg::MODE_BRK_SETUP;
		end else if (a && m == wbcc_pkg::MODE_BRK_SETUP) begin
			nxt.brk_min = brk_bump;
		end else if (s && m == wbcc_pkg::MODE_BRK_SETUP) begin
			nxt.brk_min   = brk_drop;
			nxt.saved_brk = brk_drop;
			nxt.mode      = wbcc_pkg::MODE_WRK_RUN;
		end else if (s && m == wbcc_pkg::MODE_TMR_DONE) begin
			nxt.sec  = wbcc_pkg::SEC_IDLE;
			nxt.mode = wbcc_pkg::MODE_TMR_SEL;
		end else if (s && m == wbcc_pkg::MODE_TMR_SETUP) begin
			nxt.work_min = work_drop;
			nxt.mode     = wbcc_pkg::MODE_TMR_RUN;
		end else if (s && m == wbcc_pkg::MODE_SET_OVER) begin
			nxt.work_min = st.saved_work;
			nxt.brk_min  = st.saved_brk;
			nxt.sec      = wbcc_pkg::SEC_IDLE;
			nxt.mode     = wbcc_pkg::MODE_WRK_RUN;
		end else if (a && m == wbcc_pkg::MODE_SET_OVER) begin
			nxt.work_min = wbcc_pkg::MIN_ONE;
			nxt.brk_min  = wbcc_pkg::MIN_ONE;
			nxt.sec      = wbcc_pkg::SEC_IDLE;
			nxt.mode     = wbcc_pkg::MODE_TMR_SEL;
		end else begin
			unique case (m)
				wbcc_pkg::MODE_TMR_SEL, wbcc_pkg::MODE_CYC_SEL, wbcc_pkg::MODE_TMR_SETUP,
				wbcc_pkg::MODE_WRK_SETUP, wbcc_pkg::MODE_BRK_SETUP: begin
				end
				wbcc_pkg::MODE_TMR_RUN, wbcc_pkg::MODE_WRK_RUN: begin
					if (step_due) begin
						nxt.last_ms  = now_ms;
						nxt.sec      = cd_sec_nxt;
						nxt.work_min = cd_min_nxt;
						if (cd_done) begin
							if (m == wbcc_pkg::MODE_TMR_RUN) begin
								nxt.mode = wbcc_pkg::MODE_TMR_DONE;
							end else begin
								nxt.mode = wbcc_pkg::MODE_BRK_RUN;
								tone     = wbcc_pkg::TONE_LONG;
							end
						end
					end
				end
				wbcc_pkg::MODE_BRK_RUN: begin
					if (step_due) begin
						nxt.last_ms = now_ms;
						nxt.sec     = cd_sec_nxt;
						nxt.brk_min = cd_min_nxt;
						if (cd_done) begin
							nxt.mode = wbcc_pkg::MODE_SET_OVER;
						end
					end
				end
				wbcc_pkg::MODE_TMR_DONE, wbcc_pkg::MODE_SET_OVER: begin
					tone = wbcc_pkg::TONE_SHORT;
				end
				default: begin
					nxt.mode = wbcc_pkg::MODE_TMR_SEL;
				end
			endcase
		end
	end

	assign res.mode         = nxt.mode;
	assign res.work_count   = nxt.work_min;
	assign res.break_count  = nxt.brk_min;
	assign res.seconds_left = nxt.sec;
	assign res.tone         = tone;

endmodule

/* hdl/wbcc_out_buf.sv */
// Two-entry result buffer decoupling the step logic from the result channel.
module wbcc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbcc_pkg::buf_ctl_t   ctl,
	input  wbcc_pkg::res_t       din,
	output wbcc_pkg::res_t       dout,
	output logic                 not_empty,
	output logic                 has_space
);

	wbcc_pkg::res_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (ctl.push && !ctl.pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (ctl.pop && !ctl.push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	assign dout      = ent_q[rd_ptr_q];
	assign not_empty = cnt_q != 2'd0;
	assign has_space = cnt_q != 2'd2;

endmodule

/* hdl/wbcc_regs.sv */
// APB configuration register file (countdown interval).
module wbcc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [wbcc_pkg::IntvW-1:0]  interval_ms
);

	logic [wbcc_pkg::IntvW-1:0] interval_q;
	logic                       wr_en;
	logic                       idx;

	assign idx    = paddr[2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= wbcc_pkg::INTERVAL_RST;
		end else if (wr_en && idx == wbcc_pkg::REG_INTERVAL) begin
			interval_q <= pwdata[wbcc_pkg::IntvW-1:0];
		end
	end

	always_comb begin
		unique case (idx)
			wbcc_pkg::REG_INTERVAL: prdata = {{(32-wbcc_pkg::IntvW){1'b0}}, interval_q};
			default:                prdata = '0;
		endcase
	end

	assign interval_ms = interval_q;

endmodule

/* dv/work_break_countdown_controller_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the work/break countdown controller: poll traffic, APB setup, scoreboard.
module work_break_countdown_controller_unit_tb;

	localparam int unsigned TIMEOUT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned LONG_HOLD      = 60;    // result side hold-off, well past buffer depth
	localparam logic [2:0]  ADDR_INTERVAL  = {wbcc_pkg::REG_INTERVAL, 2'b00};

	// clock, reset and cycle count
	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned cycle_count = 0;

	// APB side
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	// poll channel
	logic        poll_valid     = 1'b0;
	logic        poll_ready;
	logic [31:0] now_ms         = '0;
	logic        start_pressed  = 1'b0;
	logic        adjust_pressed = 1'b0;

	// result channel
	logic        result_valid;
	logic        result_ready   = 1'b0;
	logic [3:0]  mode;
	logic [5:0]  work_count;
	logic [5:0]  break_count;
	logic [5:0]  seconds_left;
	logic [1:0]  tone;

	// traffic shaping, written by the test sequence only
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_requests = 0;

	// scoreboard
	wbcc_pkg::res_t pending_results[$];
	int unsigned    mismatch_count = 0;

	// controller shadow state, advanced once per accepted poll transaction
	logic [wbcc_pkg::ModeW-1:0]  pred_mode;
	logic [wbcc_pkg::CountW-1:0] pred_work;
	logic [wbcc_pkg::CountW-1:0] pred_break;
	logic [wbcc_pkg::CountW-1:0] pred_sec;
	logic [wbcc_pkg::CountW-1:0] pred_saved_work;
	logic [wbcc_pkg::CountW-1:0] pred_saved_break;
	logic [wbcc_pkg::NowW-1:0]   pred_last_ms;
	logic [wbcc_pkg::IntvW-1:0]  pred_interval;

	// stimulus state
	logic [31:0] stim_now     = '0;
	int unsigned adjust_burst = 0;

	work_break_countdown_controller_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.poll_valid     (poll_valid),
		.poll_ready     (poll_ready),
		.now_ms         (now_ms),
		.start_pressed  (start_pressed),
		.adjust_pressed (adjust_pressed),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.mode           (mode),
		.work_count     (work_count),
		.break_count    (break_count),
		.seconds_left   (seconds_left),
		.tone           (tone)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: any hang ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shadow model of the controller
	// ------------------------------------------------------------------

	// One countdown poll. Returns 1 when the countdown has just run out.
	function automatic logic countdown_tick(input logic [wbcc_pkg::NowW-1:0] t,
		inout logic [wbcc_pkg::CountW-1:0] minutes);
		logic [wbcc_pkg::NowW-1:0] elapsed;
		elapsed = t - pred_last_ms;     // mod 2^32, so timestamp wrap is harmless
		if (elapsed < {12'b0, pred_interval})
			return 1'b0;
		pred_last_ms = t;
		if (pred_sec != '0) begin
			pred_sec = pred_sec - 1'b1;
			return 1'b0;
		end
		if (minutes != '0) begin
			// borrow a minute
			pred_sec = wbcc_pkg::SEC_MAX;
			minutes  = minutes - 1'b1;
			return 1'b0;
		end
		pred_sec = wbcc_pkg::SEC_IDLE;
		return 1'b1;
	endfunction

	// Button rules first (priority order), then the action of the current mode.
	task automatic advance_countdown(input logic [wbcc_pkg::NowW-1:0] t, input logic s,
		input logic a, output wbcc_pkg::res_t r);
		logic [wbcc_pkg::ModeW-1:0] m;
		logic [wbcc_pkg::ToneW-1:0] tn;
		m  = pred_mode;
		tn = wbcc_pkg::TONE_NONE;
		if (s && (m == wbcc_pkg::MODE_TMR_SEL || m == wbcc_pkg::MODE_CYC_SEL)) begin
			pred_mode = m + 1'b1;
		end else if (a && m == wbcc_pkg::MODE_TMR_SEL) begin
			pred_mode = wbcc_pkg::MODE_TMR_SETUP;
		end else if (a && m == wbcc_pkg::MODE_CYC_SEL) begin
			pred_mode = wbcc_pkg::MODE_WRK_SETUP;
		end else if (a && (m == wbcc_pkg::MODE_TMR_SETUP || m == wbcc_pkg::MODE_WRK_SETUP)) begin
			pred_work = (pred_work > wbcc_pkg::MIN_MAX) ? wbcc_pkg::MIN_ONE : pred_work + 1'b1;
		end else if (s && m == wbcc_pkg::MODE_WRK_SETUP) begin
			if (pred_work != '0)
				pred_work = pred_work - 1'b1;
			pred_saved_work = pred_work;
			pred_mode       = wbcc_pkg::MODE_BRK_SETUP;
		end else if (a && m == wbcc_pkg::MODE_BRK_SETUP) begin
			pred_break = (pred_break > wbcc_pkg::MIN_MAX) ? wbcc_pkg::MIN_ONE
			                                              : pred_break + 1'b1;
		end else if (s && m == wbcc_pkg::MODE_BRK_SETUP) begin
			if (pred_break != '0)
				pred_break = pred_break - 1'b1;
			pred_saved_break = pred_break;
			pred_mode        = wbcc_pkg::MODE_WRK_RUN;
		end else if (s && m == wbcc_pkg::MODE_TMR_DONE) begin
			pred_sec  = wbcc_pkg::SEC_IDLE;
			pred_mode = wbcc_pkg::MODE_TMR_SEL;
		end else if (s && m == wbcc_pkg::MODE_TMR_SETUP) begin
			if (pred_work != '0)
				pred_work = pred_work - 1'b1;
			pred_mode = wbcc_pkg::MODE_TMR_RUN;
		end else if (s && m == wbcc_pkg::MODE_SET_OVER) begin
			// restart the same work/break set
			pred_work  = pred_saved_work;
			pred_break = pred_saved_break;
			pred_sec   = wbcc_pkg::SEC_IDLE;
			pred_mode  = wbcc_pkg::MODE_WRK_RUN;
		end else if (a && m == wbcc_pkg::MODE_SET_OVER) begin
			pred_work  = wbcc_pkg::MIN_ONE;
			pred_break = wbcc_pkg::MIN_ONE;
			pred_sec   = wbcc_pkg::SEC_IDLE;
			pred_mode  = wbcc_pkg::MODE_TMR_SEL;
		end else begin
			case (m)
				wbcc_pkg::MODE_TMR_SEL, wbcc_pkg::MODE_CYC_SEL, wbcc_pkg::MODE_TMR_SETUP,
				wbcc_pkg::MODE_WRK_SETUP, wbcc_pkg::MODE_BRK_SETUP: begin
				end
				wbcc_pkg::MODE_TMR_RUN: begin
					if (countdown_tick(t, pred_work))
						pred_mode = wbcc_pkg::MODE_TMR_DONE;
				end
				wbcc_pkg::MODE_WRK_RUN: begin
					if (countdown_tick(t, pred_work)) begin
						tn        = wbcc_pkg::TONE_LONG;
						pred_mode = wbcc_pkg::MODE_BRK_RUN;
					end
				end
				wbcc_pkg::MODE_BRK_RUN: begin
					if (countdown_tick(t, pred_break))
						pred_mode = wbcc_pkg::MODE_SET_OVER;
				end
				wbcc_pkg::MODE_TMR_DONE, wbcc_pkg::MODE_SET_OVER: begin
					tn = wbcc_pkg::TONE_SHORT;
				end
				default: begin
					// idle and unused codes fall back to timer select
					pred_mode = wbcc_pkg::MODE_TMR_SEL;
				end
			endcase
		end
		r = '{pred_mode, pred_work, pred_break, pred_sec, tn};
	endtask

	// ------------------------------------------------------------------
	// Result side: random ready, long hold-off on request, scoreboard check
	// ------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	always @(posedge clk) begin
		wbcc_pkg::res_t want;
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual mode %0d",
					$time, mode);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("mode",         32'(want.mode),         32'(mode));
				compare_field("work_count",   32'(want.work_count),   32'(work_count));
				compare_field("break_count",  32'(want.break_count),  32'(break_count));
				compare_field("seconds_left", 32'(want.seconds_left), 32'(seconds_left));
				compare_field("tone",         32'(want.tone),         32'(tone));
			end
		end
		// a new hold-off request starts a long stretch of ready low
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Poll side
	// ------------------------------------------------------------------

	// Entered right after a rising edge. Leaves valid high after the transaction,
	// so back-to-back polls keep valid up without a glitch.
	task automatic send_poll(input logic [31:0] t, input logic s, input logic a);
		wbcc_pkg::res_t want;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			poll_valid <= 1'b0;
			@(posedge clk);
		end
		poll_valid     <= 1'b1;
		now_ms         <= t;
		start_pressed  <= s;
		adjust_pressed <= a;
		do
			@(posedge clk);
		while (!poll_ready);
		advance_countdown(t, s, a, want);
		pending_results.push_back(want);
	endtask

	// Mode-aware random poll: mostly sensible button use for the current mode,
	// some noise, timestamps mostly one interval apart.
	task automatic pick_poll(output logic [31:0] t, output logic s, output logic a);
		int unsigned r;
		int unsigned q;
		r = $urandom_range(99, 0);
		if (r < 70)
			stim_now = stim_now + pred_interval + $urandom_range(2, 0);
		else if (r < 85)
			stim_now = stim_now + $urandom_range(pred_interval, 0);
		else if (r >= 95)
			stim_now = $urandom;    // big random jump, can wrap backwards
		t = stim_now;
		s = 1'b0;
		a = 1'b0;
		r = $urandom_range(99, 0);
		q = $urandom_range(99, 0);
		if (r < 8) begin
			s = 1'($urandom_range(1, 0));
			a = 1'($urandom_range(1, 0));
		end else begin
			case (pred_mode)
				wbcc_pkg::MODE_TMR_SEL, wbcc_pkg::MODE_CYC_SEL: begin
					s = (q < 50);
					a = (q >= 25 && q < 75);
				end
				wbcc_pkg::MODE_TMR_SETUP, wbcc_pkg::MODE_WRK_SETUP,
				wbcc_pkg::MODE_BRK_SETUP: begin
					if (adjust_burst != 0) begin
						a = 1'b1;
						adjust_burst--;
					end else if (q < 3) begin
						// run the minutes count through 59, 60 and the wrap to 1,
						// ending small so the countdown stays short
						adjust_burst = 61 + $urandom_range(2, 0) -
							((pred_mode == wbcc_pkg::MODE_BRK_SETUP) ? pred_break : pred_work);
					end else begin
						a = (q < 30);
						s = (q >= 30 && q < 75);
					end
				end
				wbcc_pkg::MODE_TMR_DONE, wbcc_pkg::MODE_SET_OVER: begin
					s = (q < 40 || (q >= 65 && q < 75));
					a = (q >= 40 && q < 75);
				end
				default: begin
					// run and idle modes: leave the buttons alone
				end
			endcase
		end
	endtask

	task automatic random_polls(input int unsigned n);
		logic [31:0] t;
		logic        s;
		logic        a;
		repeat (n) begin
			pick_poll(t, s, a);
			send_poll(t, s, a);
		end
	endtask

	// ------------------------------------------------------------------
	// APB access
	// ------------------------------------------------------------------

	task automatic read_interval(input logic [wbcc_pkg::IntvW-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_INTERVAL;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {12'b0, want}) begin
			$display("%0t: interval read mismatch, expected %0d, actual %0d",
				$time, want, prdata);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Only while the block is idle: wait out all results first.
	task automatic write_interval(input logic [wbcc_pkg::IntvW-1:0] value);
		poll_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_INTERVAL;
		pwdata  <= {12'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		pred_interval = value;
		read_interval(value);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_register_reset();
		read_interval(wbcc_pkg::INTERVAL_RST);
	endtask

	// Walks the cycle-mode setup path from idle into work running, then
	// exercises the step rule: short of interval, exact interval, timestamp wrap.
	task automatic test_button_rules();
		send_poll(32'd0,          1'b0, 1'b0);  // idle falls back to timer select
		send_poll(32'hFFFF_FFFF,  1'b1, 1'b1);  // start wins over adjust: cycle select
		send_poll(32'd5,          1'b1, 1'b0);  // start in cycle select lands on unused code
		send_poll(32'd6,          1'b1, 1'b1);  // unused code: buttons ignored, back to select
		send_poll(32'd7,          1'b1, 1'b0);
		send_poll(32'd8,          1'b0, 1'b1);  // work setup
		send_poll(32'd9,          1'b0, 1'b1);  // work minutes up
		send_poll(32'd10,         1'b1, 1'b1);  // adjust outranks start in work setup
		send_poll(32'd11,         1'b1, 1'b0);  // minutes down, saved, break setup
		send_poll(32'd12,         1'b0, 1'b1);
		send_poll(32'd13,         1'b1, 1'b1);  // adjust outranks start in break setup
		send_poll(32'd14,         1'b0, 1'b0);
		send_poll(32'd15,         1'b1, 1'b0);  // into work running
		send_poll(32'd999,        1'b0, 1'b0);  // one short of the interval: no step
		send_poll(32'd1000,       1'b0, 1'b0);  // exactly one interval
		send_poll(32'd1999,       1'b0, 1'b0);
		send_poll(32'd0,          1'b0, 1'b0);  // backward stamp reads as a huge gap
		send_poll(32'hFFFF_FFFF,  1'b0, 1'b0);
		send_poll(32'd999,        1'b1, 1'b1);  // wrap of the stamp, buttons ignored
		stim_now = 32'd999;
	endtask

	task automatic test_min_interval();
		write_interval(20'd1);
		random_polls(330);
	endtask

	task automatic test_max_interval();
		write_interval(20'd1000000);
		random_polls(330);
	endtask

	// zero interval: every run-mode poll is a step
	task automatic test_zero_interval();
		write_interval(20'd0);
		random_polls(330);
	endtask

	task automatic test_full_field_interval();
		write_interval(20'hFFFFF);
		random_polls(250);
	endtask

	// Result side holds off while polls keep coming: buffer fills, poll_ready drops.
	task automatic test_result_stall();
		write_interval(wbcc_pkg::INTERVAL_RST);
		hold_requests++;
		random_polls(40);
	endtask

	initial begin
		pred_mode        = wbcc_pkg::MODE_IDLE;
		pred_work        = wbcc_pkg::MIN_ONE;
		pred_break       = wbcc_pkg::MIN_ONE;
		pred_sec         = wbcc_pkg::SEC_IDLE;
		pred_saved_work  = '0;
		pred_saved_break = '0;
		pred_last_ms     = '0;
		pred_interval    = wbcc_pkg::INTERVAL_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slow result side
		send_idle_pct = 10;
		recv_idle_pct = 77;
		test_register_reset();
		test_button_rules();
		test_min_interval();

		// slow poll side
		send_idle_pct = 77;
		recv_idle_pct = 10;
		test_max_interval();

		// full rate
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_zero_interval();
		test_result_stall();
		test_full_field_interval();

		poll_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
